[sv/mfbf_pkg.sv]
package mfbf_pkg;

  localparam int SYM_W = 8;
  localparam int POS_W = 16;
  localparam int MODE_W = 16;

  localparam logic [SYM_W-1:0] SPACE_BYTE = 8'h20;
  localparam logic [SYM_W-1:0] ZERO_BYTE = 8'h00;
  localparam logic [POS_W-1:0] POS_MAX = 16'hFFFF;
  localparam logic [MODE_W-1:0] MODE_MAX = 16'hFFFF;

  // write side of the count store, driven by the working stage
  typedef struct packed {
    logic             we;
    logic             clr;
    logic [SYM_W-1:0] sym;
  } mfbf_wr_t;

  // working stage status toward the best tracker
  typedef struct packed {
    logic adv;
    logic counted;
    logic last;
  } mfbf_step_t;

endpackage

[sv/mfbf_if.sv]
interface mfbf_in_if import mfbf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink (input valid, input symbol, input last, output ready);
endinterface

interface mfbf_out_if import mfbf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SYM_W-1:0]  mode_symbol;
  logic [MODE_W-1:0] mode_count;
  logic              found;

  modport source (output valid, output mode_symbol, output mode_count, output found,
                  input ready);
  modport sink (input valid, input mode_symbol, input mode_count, input found,
                output ready);
endinterface

[sv/most_frequent_byte_finder.sv]
// Most frequent byte finder. Bytes of a message stream in on in_ch, the final byte
// flagged by last; zero and space bytes are skipped (they still take a position).
// When the final byte's transaction completes, one result transaction follows on
// out_ch with the most frequent byte, its count (saturating at 65535) and a found
// flag, which is 0 with zero symbol and count when nothing was counted. Ties go to
// the byte that first appeared earlier. One byte is taken every cycle but for the
// stall below; the final byte is registered in the working stage, and the result is
// registered from there. The only input stall is a final byte waiting while the
// previous result is still held on out_ch. The count memory is read at acceptance
// with a registered read and forwarded from the write port, and per-entry valid
// flip-flops clear the whole table at once after each message and at reset, so there is no clearing pass.
module most_frequent_byte_finder import mfbf_pkg::*; #(
  parameter int              SYMBOL_COUNT = 256,
  parameter longint unsigned MAX_COUNT    = 65535
) (
  input logic        clk,
  input logic        rst_n,
  mfbf_in_if.sink    in_ch,
  mfbf_out_if.source out_ch
);

  // count width follows the saturation limit
  localparam int CW = $clog2(MAX_COUNT + 1);

  logic             accept;
  logic             counted_in;
  logic [POS_W-1:0] pos_r;

  // working stage: the byte whose count entry is being read
  logic             s1_valid_r;
  logic             s1_last_r;
  logic             s1_counted_r;
  logic [SYM_W-1:0] s1_sym_r;
  logic [POS_W-1:0] s1_pos_r;
  logic             s1_adv;

  logic             stall;
  logic             hit;
  logic [CW-1:0]    cur_count;
  logic [POS_W-1:0] cur_first;
  logic [CW-1:0]    new_count;
  logic [POS_W-1:0] new_first;
  mfbf_wr_t         wr;
  mfbf_step_t       step;

  assign accept = in_ch.valid && in_ch.ready;

  // skipped bytes: zero, space, and values beyond the table
  assign counted_in = (in_ch.symbol != ZERO_BYTE) && (in_ch.symbol != SPACE_BYTE) &&
                      ({1'b0, in_ch.symbol} < (SYM_W + 1)'(SYMBOL_COUNT));

  // a final byte holds the stage only while the previous result is not taken
  assign s1_adv      = s1_valid_r && !(s1_last_r && stall);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  // byte position in the message, saturating, restarting after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      if (in_ch.last) begin
        pos_r <= '0;
      end else if (pos_r != POS_MAX) begin
        pos_r <= pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
    if (accept) begin
      s1_last_r    <= in_ch.last;
      s1_counted_r <= counted_in;
      s1_sym_r     <= in_ch.symbol;
      s1_pos_r     <= pos_r;
    end
  end

  // new entry value: first sight starts at one, later sights count up to the limit
  always_comb begin
    if (!hit) begin
      new_count = CW'(1);
      new_first = s1_pos_r;
    end else begin
      new_count = (cur_count < CW'(MAX_COUNT)) ? cur_count + CW'(1) : cur_count;
      new_first = cur_first;
    end
  end

  assign wr.we  = s1_adv && s1_counted_r;
  assign wr.clr = s1_adv && s1_last_r;
  assign wr.sym = s1_sym_r;

  assign step.adv     = s1_adv;
  assign step.counted = s1_counted_r;
  assign step.last    = s1_last_r;

  mfbf_count_store #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .CW           (CW)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_sym    (in_ch.symbol),
    .wr        (wr),
    .wr_count  (new_count),
    .wr_first  (new_first),
    .hit       (hit),
    .cur_count (cur_count),
    .cur_first (cur_first)
  );

  mfbf_best_track #(
    .CW (CW)
  ) u_best (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .sym       (s1_sym_r),
    .new_count (new_count),
    .new_first (new_first),
    .stall     (stall),
    .out_ch    (out_ch)
  );

`ifndef SYNTH
  // a result transaction starts only after a final byte left the working stage
  a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(s1_valid_r && s1_last_r))
    else $error("result without a final byte");

  // nothing found means an all-zero result
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.found) |-> (out_ch.mode_count == '0 && out_ch.mode_symbol == '0))
    else $error("empty result carries data");

  // input stalls only behind a final byte blocked by a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && s1_last_r && out_ch.valid))
    else $error("unexpected input stall");

  // a counted byte in a fresh entry takes its own position
  a_first_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.we && !hit) |-> (new_first == s1_pos_r && new_count == CW'(1)))
    else $error("bad first entry");
`endif

endmodule

[sv/mfbf_count_store.sv]
module mfbf_count_store import mfbf_pkg::*; #(
  parameter int SYMBOL_COUNT = 256,
  parameter int CW = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [SYM_W-1:0] rd_sym,
  input  mfbf_wr_t         wr,
  input  logic [CW-1:0]    wr_count,
  input  logic [POS_W-1:0] wr_first,
  output logic             hit,
  output logic [CW-1:0]    cur_count,
  output logic [POS_W-1:0] cur_first
);

  localparam int IW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  logic [CW-1:0]    cnt_mem [SYMBOL_COUNT];
  logic [POS_W-1:0] pos_mem [SYMBOL_COUNT];

  logic [SYMBOL_COUNT-1:0] valid_r;
  logic [CW-1:0]           rd_count_r;
  logic [POS_W-1:0]        rd_first_r;
  logic                    byp_r;
  logic [CW-1:0]           byp_count_r;
  logic [POS_W-1:0]        byp_first_r;

  logic [IW-1:0] wr_idx;
  logic [IW-1:0] rd_idx;

  assign wr_idx = wr.sym[IW-1:0];
  assign rd_idx = rd_sym[IW-1:0];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      cnt_mem[wr_idx] <= wr_count;
      pos_mem[wr_idx] <= wr_first;
    end
    if (rd_en) begin
      rd_count_r <= cnt_mem[rd_idx];
      rd_first_r <= pos_mem[rd_idx];
    end
  end

  // forward the entry being written when a read of it is issued alongside the write, unless clearing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd_en) begin
      byp_r <= wr.we && !wr.clr && (wr.sym == rd_sym);
    end
    if (rd_en) begin
      byp_count_r <= wr_count;
      byp_first_r <= wr_first;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.clr) begin
      valid_r <= '0;
    end else if (wr.we) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  assign hit       = valid_r[wr_idx];
  assign cur_count = byp_r ? byp_count_r : rd_count_r;
  assign cur_first = byp_r ? byp_first_r : rd_first_r;

endmodule

[sv/mfbf_best_track.sv]
module mfbf_best_track import mfbf_pkg::*; #(
  parameter int CW = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mfbf_step_t       step,
  input  logic [SYM_W-1:0] sym,
  input  logic [CW-1:0]    new_count,
  input  logic [POS_W-1:0] new_first,
  output logic             stall,
  mfbf_out_if.source       out_ch
);

  localparam int EW = (CW > MODE_W) ? CW : MODE_W;

  logic [SYM_W-1:0]  best_sym_r;
  logic [CW-1:0]     best_cnt_r;
  logic [POS_W-1:0]  best_first_r;
  logic              better;
  logic [SYM_W-1:0]  b_sym;
  logic [CW-1:0]     b_cnt;
  logic [POS_W-1:0]  b_first;
  logic [EW-1:0]     cnt_ext;
  logic              found_nxt;
  logic [MODE_W-1:0] mode_count_nxt;
  logic              out_valid_r;
  logic [SYM_W-1:0]  out_sym_r;
  logic [MODE_W-1:0] out_count_r;
  logic              out_found_r;

  assign better = step.counted &&
                  ((new_count > best_cnt_r) ||
                   ((new_count == best_cnt_r) && (new_first < best_first_r)));

  assign b_sym   = better ? sym : best_sym_r;
  assign b_cnt   = better ? new_count : best_cnt_r;
  assign b_first = better ? new_first : best_first_r;

  assign cnt_ext        = EW'(b_cnt);
  assign found_nxt      = (b_cnt != '0);
  assign mode_count_nxt = (cnt_ext > EW'(MODE_MAX)) ? MODE_MAX : cnt_ext[MODE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_sym_r   <= '0;
      best_cnt_r   <= '0;
      best_first_r <= '0;
    end else if (step.adv) begin
      if (step.last) begin
        best_sym_r   <= '0;
        best_cnt_r   <= '0;
        best_first_r <= '0;
      end else begin
        best_sym_r   <= b_sym;
        best_cnt_r   <= b_cnt;
        best_first_r <= b_first;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step.adv && step.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (step.adv && step.last) begin
      out_sym_r   <= found_nxt ? b_sym : '0;
      out_count_r <= found_nxt ? mode_count_nxt : '0;
      out_found_r <= found_nxt;
    end
  end

  assign stall              = out_valid_r && !out_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.mode_symbol = out_sym_r;
  assign out_ch.mode_count  = out_count_r;
  assign out_ch.found       = out_found_r;

endmodule

[test/most_frequent_byte_finder_tb.sv]
module most_frequent_byte_finder_tb;
  import mfbf_pkg::*;

  // count limit of the instance below, which keeps its default parameters
  localparam int unsigned COUNT_LIMIT = 65535;

  typedef struct {
    logic [SYM_W-1:0]  mode_symbol;
    logic [MODE_W-1:0] mode_count;
    logic              found;
  } mode_result_t;

  // running tally of one message and the queue of modes still to come out
  class mode_tally;
    int unsigned       sym_count[256];
    bit [POS_W-1:0]    first_pos[256];
    bit                seen[256];
    bit [POS_W-1:0]    position;
    bit [SYM_W-1:0]    best_sym;
    int unsigned       best_count;
    bit [POS_W-1:0]    best_first;
    mode_result_t      expected_modes[$];
    int unsigned       mismatches;

    // accepted input transaction
    function void note_byte(logic [SYM_W-1:0] sym, logic last);
      mode_result_t res;
      if (sym != ZERO_BYTE && sym != SPACE_BYTE) begin
        if (!seen[sym]) begin
          seen[sym] = 1'b1;
          sym_count[sym] = 1;
          first_pos[sym] = position;
        end else if (sym_count[sym] < COUNT_LIMIT) begin
          sym_count[sym]++;
        end
        if (sym_count[sym] > best_count ||
            (sym_count[sym] == best_count && first_pos[sym] < best_first)) begin
          best_sym = sym;
          best_count = sym_count[sym];
          best_first = first_pos[sym];
        end
      end
      if (position != POS_MAX) position++;
      if (last) begin
        if (best_count > 0) begin
          res.mode_symbol = best_sym;
          res.mode_count = (best_count > MODE_MAX) ? MODE_MAX : best_count[MODE_W-1:0];
          res.found = 1'b1;
        end else begin
          res.mode_symbol = '0;
          res.mode_count = '0;
          res.found = 1'b0;
        end
        expected_modes.push_back(res);
        foreach (seen[i]) seen[i] = 1'b0;
        position = '0;
        best_sym = '0;
        best_count = 0;
        best_first = '0;
      end
    endfunction

    // accepted result transaction against the oldest expected mode
    function void check_mode(logic [SYM_W-1:0] sym, logic [MODE_W-1:0] cnt, logic found);
      mode_result_t exp_res;
      if (expected_modes.size() == 0) begin
        $error("unexpected result: mode_symbol %0h mode_count %0d found %0b", sym, cnt, found);
        mismatches++;
        return;
      end
      exp_res = expected_modes.pop_front();
      if (sym !== exp_res.mode_symbol) begin
        $error("mode_symbol: expected %0h, actual %0h", exp_res.mode_symbol, sym);
        mismatches++;
      end
      if (cnt !== exp_res.mode_count) begin
        $error("mode_count: expected %0d, actual %0d", exp_res.mode_count, cnt);
        mismatches++;
      end
      if (found !== exp_res.found) begin
        $error("found: expected %0b, actual %0b", exp_res.found, found);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  mfbf_in_if  in_ch ();
  mfbf_out_if out_ch ();

  most_frequent_byte_finder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mode_tally tally = new;

  // idle bursts on both sides are allowed while this is set
  bit idling_on = 1'b1;

  // small alphabet of the current random message
  logic [SYM_W-1:0] alphabet[4];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // one byte transaction; valid stays high into the next byte unless a gap is taken
  task automatic send_byte(input logic [SYM_W-1:0] sym, input logic last);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.symbol <= sym;
    in_ch.last   <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tally.note_byte(sym, last);
  endtask

  // ascii message, last flag on its final character
  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_byte(text[i], i == text.len() - 1);
  endtask

  // sender holds off until every expected mode has been seen
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (tally.expected_modes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [SYM_W-1:0] random_symbol(input int style);
    logic [SYM_W-1:0] sym;
    case (style)
      0: begin
        sym = SYM_W'($urandom_range(0, 255));
      end
      3: begin
        // mostly skipped bytes, so many messages end with nothing counted
        if ($urandom_range(0, 3) != 0) sym = $urandom_range(0, 1) ? SPACE_BYTE : ZERO_BYTE;
        else sym = SYM_W'($urandom_range(0, 255));
      end
      default: begin
        // few distinct bytes give real counts and plenty of ties
        if ($urandom_range(0, 7) == 0) sym = $urandom_range(0, 1) ? SPACE_BYTE : ZERO_BYTE;
        else sym = alphabet[$urandom_range(0, 3)];
      end
    endcase
    return sym;
  endfunction

  // result side: check each accepted transaction, then pick the next ready
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        tally.check_mode(out_ch.mode_symbol, out_ch.mode_count, out_ch.found);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned random_sent;
    int          len;
    int          style;
    random_sent = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.symbol = '0;
    in_ch.last = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // one counted byte that is also the final byte
    send_byte(8'h41, 1'b1);
    // only skipped bytes: nothing found
    send_byte(SPACE_BYTE, 1'b0);
    send_byte(ZERO_BYTE, 1'b1);
    // extreme values tie on count, the earlier first occurrence wins
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(SPACE_BYTE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(ZERO_BYTE, 1'b0);
    send_byte(8'h01, 1'b1);
    // the later byte reaches the tie, yet was seen first
    send_text("baab");
    // final byte skipped, tie settled by first position
    send_text("xyzzy ");
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);
    wait_drained();

    // random messages; the last stretch has no idling at all
    while (random_sent < 1000) begin
      if (random_sent >= 850) idling_on = 1'b0;
      else idling_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) wait_drained();
      style = $urandom_range(0, 3);
      foreach (alphabet[k]) alphabet[k] = SYM_W'($urandom_range(0, 255));
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 24);
      for (int i = 0; i < len; i++) send_byte(random_symbol(style), i == len - 1);
      random_sent += len;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (tally.mismatches == 0 && tally.expected_modes.size() == 0) begin
      $display("most_frequent_byte_finder regression: pass");
    end else begin
      $display("most_frequent_byte_finder regression: fail");
    end
    $finish;
  end

  // hang guard
  initial begin
    #800000;
    $display("most_frequent_byte_finder regression: fail");
    $finish;
  end

endmodule

[files.f]
sv/mfbf_pkg.sv
sv/mfbf_if.sv
sv/mfbf_count_store.sv
sv/mfbf_best_track.sv
sv/most_frequent_byte_finder.sv
test/most_frequent_byte_finder_tb.sv
